// File: hdl/assert_macros.svh
// Assertion macros for the bfscc RTL modules; included by bfscc_datapath.
// Expects signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BFSCC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define BFSCC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/bfscc_pkg.sv
// Shared constants, opcodes and controller/datapath interface types for the
// connected-components block. No dependencies.
`timescale 1ns / 1ps

package bfscc_pkg;

   localparam int MAX_VERTICES = 32;
   localparam int EDGE_CAP     = 256;
   localparam int FIELD_CAP    = 32;
   localparam int VTX_CAP      = (MAX_VERTICES < FIELD_CAP) ? MAX_VERTICES : FIELD_CAP;

   localparam int VTX_W        = 5;
   localparam int CFG_W        = 6;
   localparam int COMP_CNT_W   = 6;
   localparam int QUEUE_AW     = (VTX_CAP > 1) ? $clog2(VTX_CAP) : 1;
   localparam int VCNT_W       = $clog2(VTX_CAP + 1);
   localparam int EDGE_AW      = (EDGE_CAP > 1) ? $clog2(EDGE_CAP) : 1;
   localparam int ECNT_W       = $clog2(EDGE_CAP + 1);

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_RUN   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef struct packed {
      logic [VTX_W-1:0] vertex;
      logic [VTX_W-1:0] comp;
   } queue_entry_type;

   typedef struct packed {
      logic add;
      logic clear;
      logic run_init;
      logic seed;
      logic deq;
      logic scan;
      logic out;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic seed_done;
      logic seed_hit;
      logic queue_empty;
      logic scan_done;
      logic out_done;
   } dp_status_type;

endpackage

// File: hdl/bfscc_ctrl.sv
// Sequencing state machine for the connected-components block.
// Depends on bfscc_pkg; drives commands to bfscc_datapath.
`timescale 1ns / 1ps

module bfscc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [1:0]              req_opcode,
   input  bfscc_pkg::dp_status_type status,
   output logic                    busy,
   output bfscc_pkg::ctl_cmd_type  cmd
);
   import bfscc_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SEED = 3'd1;
   localparam logic [2:0] ST_DEQ  = 3'd2;
   localparam logic [2:0] ST_SCAN = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_opcode)
                  OP_ADD:   cmd.add = 1'b1;
                  OP_CLEAR: cmd.clear = 1'b1;
                  OP_RUN: begin
                     cmd.run_init = 1'b1;
                     state_in     = ST_SEED;
                  end
                  default: ;
               endcase
            end
         end
         ST_SEED: begin
            cmd.seed = 1'b1;
            if (status.seed_done) begin
               state_in = ST_OUT;
            end else if (!status.seed_hit) begin
               state_in = ST_DEQ;
            end
         end
         ST_DEQ: begin
            cmd.deq  = 1'b1;
            state_in = status.queue_empty ? ST_SEED : ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ST_DEQ;
            end
         end
         ST_OUT: begin
            cmd.out = 1'b1;
            if (status.out_done) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// File: hdl/bfscc_datapath.sv
// Edge store, visited map, vertex queue and walk counters.
// Depends on bfscc_pkg and assert_macros.svh; commanded by bfscc_ctrl.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bfscc_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  bfscc_pkg::ctl_cmd_type             cmd,
   input  logic                               csr_we,
   input  logic [bfscc_pkg::CFG_W-1:0]        csr_wdata,
   input  logic [bfscc_pkg::VTX_W-1:0]        req_end_a,
   input  logic [bfscc_pkg::VTX_W-1:0]        req_end_b,
   output bfscc_pkg::dp_status_type           status,
   output logic                               rsp_strobe,
   output logic [bfscc_pkg::VTX_W-1:0]        rsp_vertex,
   output logic [bfscc_pkg::VTX_W-1:0]        rsp_component,
   output logic [bfscc_pkg::COMP_CNT_W-1:0]   rsp_component_count,
   output logic                               rsp_edge_dropped,
   output logic                               rsp_last
);
   import bfscc_pkg::*;

   logic [CFG_W-1:0]     vcount_ff, vcount_in;
   logic [VCNT_W-1:0]    n_eff;
   logic [VTX_W:0]       n_cmp;

   logic [2*VTX_W-1:0]   edge_mem [EDGE_CAP];
   logic [2*VTX_W-1:0]   edge_rd_ff;
   logic [ECNT_W-1:0]    edge_total_ff, edge_total_in;
   logic                 drop_ff, drop_in;

   queue_entry_type      queue_mem [VTX_CAP];
   queue_entry_type      q_rd_ff;
   queue_entry_type      q_wr_data;
   logic [QUEUE_AW-1:0]  q_rd_addr;

   logic [FIELD_CAP-1:0] visited_ff, visited_in;
   logic [VCNT_W-1:0]    s_ff, s_in;
   logic [VCNT_W-1:0]    head_ff, head_in;
   logic [VCNT_W-1:0]    tail_ff, tail_in;
   logic [VCNT_W-1:0]    k_ff, k_in;
   logic [VCNT_W-1:0]    comps_ff, comps_in;
   logic [ECNT_W-1:0]    e_ff, e_in;
   logic                 scan_pend_ff, scan_pend_in;
   logic                 out_pend_ff, out_pend_in;

   logic                 add_ok;
   logic [VTX_W-1:0]     s_vtx;
   logic                 seed_push;
   logic                 deq_pop;
   logic                 scan_issue;
   logic                 out_issue;
   logic [VTX_W-1:0]     ea, eb, nb;
   logic                 nb_match;
   logic                 scan_push;

   always_comb begin
      if (vcount_ff == '0) begin
         n_eff = VCNT_W'(1);
      end else if (vcount_ff > CFG_W'(VTX_CAP)) begin
         n_eff = VCNT_W'(VTX_CAP);
      end else begin
         n_eff = VCNT_W'(vcount_ff);
      end
   end

   assign n_cmp  = (VTX_W + 1)'(n_eff);
   assign add_ok = ({1'b0, req_end_a} < n_cmp) && ({1'b0, req_end_b} < n_cmp) &&
                   (edge_total_ff < ECNT_W'(EDGE_CAP));

   assign s_vtx     = VTX_W'(s_ff);
   assign seed_push = cmd.seed && !status.seed_done && !status.seed_hit;
   assign deq_pop   = cmd.deq && !status.queue_empty;
   assign scan_issue = cmd.scan && (e_ff < edge_total_ff);
   assign out_issue  = cmd.out && (k_ff < tail_ff);

   assign ea = edge_rd_ff[2*VTX_W-1:VTX_W];
   assign eb = edge_rd_ff[VTX_W-1:0];

   always_comb begin
      nb       = '0;
      nb_match = 1'b0;
      if (({1'b0, ea} < n_cmp) && ({1'b0, eb} < n_cmp)) begin
         if (ea == q_rd_ff.vertex) begin
            nb       = eb;
            nb_match = 1'b1;
         end else if (eb == q_rd_ff.vertex) begin
            nb       = ea;
            nb_match = 1'b1;
         end
      end
   end

   assign scan_push = scan_pend_ff && nb_match && !visited_ff[nb] &&
                      (tail_ff < VCNT_W'(VTX_CAP));

   assign q_wr_data.vertex = seed_push ? s_vtx : nb;
   assign q_wr_data.comp   = VTX_W'(comps_ff);
   assign q_rd_addr        = deq_pop ? QUEUE_AW'(head_ff) : QUEUE_AW'(k_ff);

   always_comb begin
      vcount_in     = vcount_ff;
      edge_total_in = edge_total_ff;
      drop_in       = drop_ff;
      visited_in    = visited_ff;
      s_in          = s_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      k_in          = k_ff;
      comps_in      = comps_ff;
      e_in          = e_ff;
      scan_pend_in  = scan_issue;
      out_pend_in   = out_issue;

      if (csr_we) begin
         vcount_in = csr_wdata;
      end
      if (cmd.add) begin
         if (add_ok) begin
            edge_total_in = edge_total_ff + 1'b1;
         end else begin
            drop_in = 1'b1;
         end
      end
      if (cmd.clear) begin
         edge_total_in = '0;
      end
      if (cmd.finish) begin
         drop_in = 1'b0;
      end
      if (cmd.run_init) begin
         visited_in = '0;
         s_in       = '0;
         head_in    = '0;
         tail_in    = '0;
         k_in       = '0;
         comps_in   = '0;
      end
      if (cmd.seed && !status.seed_done) begin
         s_in = s_ff + 1'b1;
      end
      if (seed_push) begin
         visited_in[s_vtx] = 1'b1;
         tail_in           = tail_ff + 1'b1;
      end
      if (cmd.deq) begin
         e_in = '0;
         if (status.queue_empty) begin
            comps_in = comps_ff + 1'b1;
         end else begin
            head_in = head_ff + 1'b1;
         end
      end
      if (scan_issue) begin
         e_in = e_ff + 1'b1;
      end
      if (scan_push) begin
         visited_in[nb] = 1'b1;
         tail_in        = tail_ff + 1'b1;
      end
      if (out_issue) begin
         k_in = k_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff     <= CFG_W'(VTX_CAP);
         edge_total_ff <= '0;
         drop_ff       <= 1'b0;
         visited_ff    <= '0;
         s_ff          <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         k_ff          <= '0;
         comps_ff      <= '0;
         e_ff          <= '0;
         scan_pend_ff  <= 1'b0;
         out_pend_ff   <= 1'b0;
      end else begin
         vcount_ff     <= vcount_in;
         edge_total_ff <= edge_total_in;
         drop_ff       <= drop_in;
         visited_ff    <= visited_in;
         s_ff          <= s_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         k_ff          <= k_in;
         comps_ff      <= comps_in;
         e_ff          <= e_in;
         scan_pend_ff  <= scan_pend_in;
         out_pend_ff   <= out_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add && add_ok) begin
         edge_mem[edge_total_ff[EDGE_AW-1:0]] <= {req_end_a, req_end_b};
      end
      if (scan_issue) begin
         edge_rd_ff <= edge_mem[e_ff[EDGE_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (seed_push || scan_push) begin
         queue_mem[QUEUE_AW'(tail_ff)] <= q_wr_data;
      end
      if (deq_pop || out_issue) begin
         q_rd_ff <= queue_mem[q_rd_addr];
      end
   end

   assign status.seed_done   = (s_ff == n_eff);
   assign status.seed_hit    = visited_ff[s_vtx];
   assign status.queue_empty = (head_ff == tail_ff);
   assign status.scan_done   = (e_ff == edge_total_ff) && !scan_pend_ff;
   assign status.out_done    = (k_ff == tail_ff) && !out_pend_ff;

   assign rsp_strobe          = out_pend_ff;
   assign rsp_vertex          = q_rd_ff.vertex;
   assign rsp_component       = q_rd_ff.comp;
   assign rsp_last            = out_pend_ff && (k_ff == tail_ff);
   assign rsp_component_count = rsp_last ? COMP_CNT_W'(comps_ff) : '0;
   assign rsp_edge_dropped    = drop_ff;

   `BFSCC_ASSERT(a_tail_cap, tail_ff <= VCNT_W'(VTX_CAP), "queue tail beyond capacity")
   `BFSCC_ASSERT(a_head_le_tail, head_ff <= tail_ff, "queue head passed tail")
   `BFSCC_ASSERT(a_edge_cap, edge_total_ff <= ECNT_W'(EDGE_CAP), "edge count beyond capacity")
   `BFSCC_ASSERT_NEXT(a_last_ends, out_pend_ff && rsp_last, !out_pend_ff, "transfer after last")

endmodule

// File: hdl/bfs_connected_components.sv
// Connected components by breadth-first walk over a stored edge list.
// Add and clear complete without leaving idle; busy stays low after them.
// A run keeps busy high until its last result is out, and each dequeued vertex scans
// every stored edge, one per cycle through the edge store read port.
// Results leave one per cycle at the end of a run, marked by rsp_strobe; the receiver cannot stall.
// Synchronous active-high reset: edge store empty, vertex_count 32, drop flag clear.
`timescale 1ns / 1ps

module bfs_connected_components (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_opcode,
   input  logic [bfscc_pkg::VTX_W-1:0]      req_end_a,
   input  logic [bfscc_pkg::VTX_W-1:0]      req_end_b,
   input  logic                             csr_we,
   input  logic [bfscc_pkg::CFG_W-1:0]      csr_wdata,
   output logic                             rsp_strobe,
   output logic [bfscc_pkg::VTX_W-1:0]      rsp_vertex,
   output logic [bfscc_pkg::VTX_W-1:0]      rsp_component,
   output logic [bfscc_pkg::COMP_CNT_W-1:0] rsp_component_count,
   output logic                             rsp_edge_dropped,
   output logic                             rsp_last
);
   import bfscc_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   bfscc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .status     (status),
      .busy       (busy),
      .cmd        (cmd)
   );

   bfscc_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .req_end_a           (req_end_a),
      .req_end_b           (req_end_b),
      .status              (status),
      .rsp_strobe          (rsp_strobe),
      .rsp_vertex          (rsp_vertex),
      .rsp_component       (rsp_component),
      .rsp_component_count (rsp_component_count),
      .rsp_edge_dropped    (rsp_edge_dropped),
      .rsp_last            (rsp_last)
   );

endmodule
